// ===== sv/sha_pkg.sv =====
// Package for the SHA-256 message hasher: constants, round table and round functions.
// No dependencies; used by all modules of the hasher.
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [6:0] LenStart = 7'd56;

  // Command passed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } cmd_t;

  function automatic logic [31:0] init_value(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== sv/sha_front.sv =====
// Front part of the SHA-256 hasher: accepts input transactions and queues commands.
// Depends on sha_pkg.
module sha_front #(
  parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sha_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output sha_pkg::cmd_t cmd
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha_pkg::cmd_t    queue [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  // Empty items carry no work and are dropped here.
  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign push      = in_valid && in_ready && (in_cmd.has_byte || in_cmd.end_of_message);
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== sv/sha_back.sv =====
// Back part of the SHA-256 hasher: block packing, padding, 64-round compression, digest out.
// Depends on sha_pkg.
module sha_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sha_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   digest_word,
  output logic [2:0]    word_index,
  output logic          last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ROUND, S_FINAL, S_EMIT
  } state_t;

  state_t       state;
  logic [31:0]  hash_words [8];
  logic [31:0]  block_buffer [16];
  logic [6:0]   block_byte_count;
  logic [63:0]  message_bit_count;
  logic [31:0]  sched [16];
  logic [31:0]  wv [8];
  logic [5:0]   round;
  logic         pending_eom;
  logic         length_done;
  logic [2:0]   emit_idx;

  logic [5:0]   pos;
  logic [31:0]  w_cur;
  logic [31:0]  s0;
  logic [31:0]  s1;
  logic [31:0]  t1;
  logic [31:0]  t2;

  assign pos = block_byte_count[5:0];

  // Message schedule word and round sums for the current round.
  always_comb begin
    s0 = '0;
    s1 = '0;
    if (round < 6'd16) begin
      w_cur = block_buffer[round[3:0]];
    end else begin
      s0 = sha_pkg::rotr(sched[4'(round - 6'd15)], 7) ^ sha_pkg::rotr(sched[4'(round - 6'd15)], 18)
           ^ (sched[4'(round - 6'd15)] >> 3);
      s1 = sha_pkg::rotr(sched[4'(round - 6'd2)], 17) ^ sha_pkg::rotr(sched[4'(round - 6'd2)], 19)
           ^ (sched[4'(round - 6'd2)] >> 10);
      w_cur = sched[round[3:0]] + s0 + sched[4'(round - 6'd7)] + s1;
    end
    t1 = wv[7] + (sha_pkg::rotr(wv[4], 6) ^ sha_pkg::rotr(wv[4], 11) ^ sha_pkg::rotr(wv[4], 25))
         + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + sha_pkg::RoundK[round] + w_cur;
    t2 = (sha_pkg::rotr(wv[0], 2) ^ sha_pkg::rotr(wv[0], 13) ^ sha_pkg::rotr(wv[0], 22))
         + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  assign cmd_ready   = (state == S_IDLE);
  assign out_valid   = (state == S_EMIT);
  assign digest_word = hash_words[emit_idx];
  assign word_index  = emit_idx;
  assign last_word   = (emit_idx == 3'd7);

  // Sequencer: takes a command, packs, pads, runs rounds, emits the digest.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      block_byte_count  <= '0;
      message_bit_count <= '0;
      pending_eom       <= 1'b0;
      length_done       <= 1'b0;
      emit_idx          <= '0;
      round             <= '0;
      for (int j = 0; j < 8; j++) hash_words[j] <= sha_pkg::init_value(3'(j));
      for (int j = 0; j < 16; j++) block_buffer[j] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            pending_eom <= cmd.end_of_message;
            length_done <= 1'b0;
            if (cmd.has_byte) begin
              block_buffer[pos[5:2]] <= block_buffer[pos[5:2]]
                                        | ({24'd0, cmd.data_byte} << ((2'd3 - pos[1:0]) * 8));
              block_byte_count  <= block_byte_count + 7'd1;
              message_bit_count <= message_bit_count + 64'd8;
              if (pos == 6'd63) begin
                state <= S_ROUND;
                round <= '0;
                for (int j = 0; j < 8; j++) wv[j] <= hash_words[j];
              end else if (cmd.end_of_message) begin
                state <= S_PAD;
              end
            end else begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // Append the pad byte, then the length, compressing as needed.
          if (!length_done) begin
            block_buffer[pos[5:2]] <= block_buffer[pos[5:2]]
                                      | ({24'd0, sha_pkg::PadByte} << ((2'd3 - pos[1:0]) * 8));
            block_byte_count <= block_byte_count + 7'd1;
            length_done      <= 1'b1;
            if (block_byte_count + 7'd1 > sha_pkg::LenStart) begin
              state <= S_ROUND;
              round <= '0;
              for (int j = 0; j < 8; j++) wv[j] <= hash_words[j];
            end
          end else begin
            block_buffer[14] <= message_bit_count[63:32];
            block_buffer[15] <= message_bit_count[31:0];
            pending_eom      <= 1'b0;
            state            <= S_ROUND;
            round            <= '0;
            for (int j = 0; j < 8; j++) wv[j] <= hash_words[j];
          end
        end
        S_ROUND: begin
          sched[round[3:0]] <= w_cur;
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          // Fold the working variables in and clear the block.
          for (int j = 0; j < 8; j++) hash_words[j] <= hash_words[j] + wv[j];
          for (int j = 0; j < 16; j++) block_buffer[j] <= '0;
          block_byte_count <= '0;
          if (pending_eom) begin
            state <= S_PAD;
          end else if (length_done) begin
            state    <= S_EMIT;
            emit_idx <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              state             <= S_IDLE;
              length_done       <= 1'b0;
              message_bit_count <= '0;
              for (int j = 0; j < 8; j++) hash_words[j] <= sha_pkg::init_value(3'(j));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/sha256_message_hasher.sv =====
// Top level of the SHA-256 message hasher: command queue in front, compression core behind.
// Depends on sha_pkg, sha_front and sha_back.
//
//  channel | direction | payload
//  s_axis  | in        | tdata: data_byte; tuser: has_byte, end_of_message
//  m_axis  | out       | tdata: digest_word; tuser: word_index, last_word
//
// Each byte is packed into the block buffer; a full block then runs 64 rounds plus a fold
// step on the shared round unit, during which the core takes no new bytes. Closing a message
// adds pad steps, one or two compressions and eight digest transactions.
// Reset is synchronous and restores the initial hash values. The queue lets input
// transactions be taken while the core computes or waits on m_axis_tready.
module sha256_message_hasher #(
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [0] has_byte, [1] end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [3:0]  m_axis_tuser    // [2:0] word_index, [3] last_word
);

  sha_pkg::cmd_t in_cmd;
  sha_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  assign in_cmd.data_byte      = s_axis_tdata;
  assign in_cmd.has_byte       = s_axis_tuser[0];
  assign in_cmd.end_of_message = s_axis_tuser[1];

  sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  sha_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .digest_word(m_axis_tdata), .word_index(m_axis_tuser[2:0]), .last_word(m_axis_tuser[3])
  );

endmodule
